@@ rtl/core/ttcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Text terminal cursor and scroll: shared definitions
// Geometry limits, character codes, register map, payload structs and the
// controller state type.
// ----------------------------------------------------------------------------
package ttcs_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 64;

   localparam int COL_W  = 7;              // width of a column number
   localparam int ROW_W  = 6;              // width of a row number
   localparam int NCOL_W = COL_W + 1;      // column count, holds MAX_COLUMNS
   localparam int NROW_W = ROW_W + 1;      // row count, holds MAX_ROWS
   localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
   localparam logic [7:0] CODE_BACKSPACE = 8'h08;
   localparam logic [7:0] CODE_SPACE     = 8'h20;

   localparam logic [NCOL_W-1:0] COLUMNS_RESET = 8'd80;
   localparam logic [NROW_W-1:0] ROWS_RESET    = 7'd30;

   // Register selected by paddr[2]; registers sit at byte addresses 0 and 4.
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_COLUMNS = 1'b0;
   localparam logic CSR_IDX_ROWS    = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic             cell_written;
      logic [ROW_W-1:0] write_row;
      logic [COL_W-1:0] write_column;
      logic [7:0]       write_value;
      logic             scrolled;
      logic             cleared;
      logic [ROW_W-1:0] cursor_row_out;
      logic [COL_W-1:0] cursor_column_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_REDUCE,
      ST_WRITE,
      ST_BLANK,
      ST_CLEAR
   } state_type;

endpackage

@@ rtl/core/ttcs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ttcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/text_terminal_cursor_scroll.sv @@
// ----------------------------------------------------------------------------
// Text terminal cursor and scroll engine
// Keeps a character-cell screen store and a cursor; handles put-character
// and clear-screen requests, with line wrap and ring-offset scrolling.
// ----------------------------------------------------------------------------
// Usage. Each request on the req_ channel carries a mode bit and a character
// code; each request produces exactly one response on the rsp_ channel with
// the cell written (if any), the scroll and clear flags and the new cursor.
// The response is registered into the output register, or into a second
// response slot while a response waits there, so the block can take the next
// request while a response waits. After a put request is accepted, req_stall
// stays high while the ring offset is reduced below a row count that was
// made smaller (at most 63 subtractions), while the store update runs and,
// when it scrolls, while all 128 cells of the new bottom row are blanked;
// the next request is taken once the block is idle again.
// A clear request sweeps the whole 8192-entry store before the next request
// is taken. After reset the same sweep runs once while no request is
// taken; configuration writes are accepted throughout. If the receiver stalls
// rsp_, at most two responses are held and req_stall rises until one leaves.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ttcs_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ttcs_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ttcs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int COL_W  = ttcs_pkg::COL_W;
   localparam int ROW_W  = ttcs_pkg::ROW_W;
   localparam int NCOL_W = ttcs_pkg::NCOL_W;
   localparam int NROW_W = ttcs_pkg::NROW_W;
   localparam int ADDR_W = ttcs_pkg::ADDR_W;

   // Controller state and sweep counter.
   ttcs_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;

   // Architectural state held in flip-flops; the cells live in the RAM.
   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ROW_W-1:0]  blank_row_ff, blank_row_in;
   logic [NCOL_W-1:0] columns_ff, columns_in;
   logic [NROW_W-1:0] rows_ff, rows_in;

   // The accepted request, waiting for its store update.
   logic              item_write_ff, item_write_in;
   logic              item_scroll_ff, item_scroll_in;
   logic [ROW_W-1:0]  item_row_ff, item_row_in;
   logic [COL_W-1:0]  item_col_ff, item_col_in;
   logic [7:0]        item_val_ff, item_val_in;

   // Response register and its second slot.
   logic              out_valid_ff, out_valid_in;
   ttcs_pkg::rsp_type out_ff, out_in;
   logic              hold_valid_ff, hold_valid_in;
   ttcs_pkg::rsp_type hold_ff, hold_in;

   // Store write port.
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;

   // Read-back of the last store write, watched by an assertion below.
   logic              chk_valid_ff, chk_pend_ff;
   logic [ADDR_W-1:0] chk_addr_ff;
   logic [7:0]        chk_data_ff, chk_exp_ff;

   logic              req_accept;
   logic              rsp_drain;
   logic              csr_write;
   logic [NCOL_W-1:0] cols_eff;
   logic [NROW_W-1:0] rows_eff;
   logic [ROW_W-1:0]  row_sat;
   logic [COL_W-1:0]  col_sat;
   logic [NCOL_W-1:0] col_inc;
   logic              nl_scroll;
   logic [ROW_W-1:0]  nl_row;
   logic [NROW_W-1:0] phys_sum;
   logic [ROW_W-1:0]  phys_row;
   logic [NROW_W-1:0] top_inc;
   ttcs_pkg::rsp_type rsp_new;

   // Effective geometry: a count of zero acts as one, and counts are limited
   // to the size of the store.
   always_comb begin
      if (columns_ff == '0) begin
         cols_eff = NCOL_W'(1);
      end else if (columns_ff > NCOL_W'(ttcs_pkg::MAX_COLUMNS)) begin
         cols_eff = NCOL_W'(ttcs_pkg::MAX_COLUMNS);
      end else begin
         cols_eff = columns_ff;
      end
      if (rows_ff == '0) begin
         rows_eff = NROW_W'(1);
      end else if (rows_ff > NROW_W'(ttcs_pkg::MAX_ROWS)) begin
         rows_eff = NROW_W'(ttcs_pkg::MAX_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
   end

   // The cursor is pulled inside the geometry before a put is handled, as it
   // may lie outside after a geometry change without a clear.
   always_comb begin
      if ({1'b0, cursor_row_ff} >= rows_eff) begin
         row_sat = ROW_W'(rows_eff - NROW_W'(1));
      end else begin
         row_sat = cursor_row_ff;
      end
      if ({1'b0, cursor_col_ff} >= cols_eff) begin
         col_sat = COL_W'(cols_eff - NCOL_W'(1));
      end else begin
         col_sat = cursor_col_ff;
      end
      col_inc   = {1'b0, col_sat} + NCOL_W'(1);
      nl_scroll = ({1'b0, row_sat} + NROW_W'(1)) >= rows_eff;
      nl_row    = nl_scroll ? row_sat : row_sat + ROW_W'(1);
   end

   // Response of the request on the input, and the cursor after it.
   always_comb begin
      rsp_new        = '0;
      item_write_in  = 1'b0;
      item_scroll_in = 1'b0;
      item_row_in    = row_sat;
      item_col_in    = col_sat;
      item_val_in    = req_data.char_code;
      if (req_data.mode) begin
         rsp_new.cleared = 1'b1;
      end else begin
         case (req_data.char_code)
            ttcs_pkg::CODE_NEWLINE: begin
               item_scroll_in            = nl_scroll;
               rsp_new.cursor_row_out    = nl_row;
               rsp_new.cursor_column_out = '0;
            end
            ttcs_pkg::CODE_BACKSPACE: begin
               rsp_new.cursor_row_out = row_sat;
               if (col_sat != '0) begin
                  item_write_in             = 1'b1;
                  item_col_in               = col_sat - COL_W'(1);
                  item_val_in               = ttcs_pkg::CODE_SPACE;
                  rsp_new.cursor_column_out = col_sat - COL_W'(1);
               end else begin
                  rsp_new.cursor_column_out = col_sat;
               end
            end
            default: begin
               item_write_in = 1'b1;
               if (col_inc >= cols_eff) begin
                  item_scroll_in            = nl_scroll;
                  rsp_new.cursor_row_out    = nl_row;
                  rsp_new.cursor_column_out = '0;
               end else begin
                  rsp_new.cursor_row_out    = row_sat;
                  rsp_new.cursor_column_out = col_inc[COL_W-1:0];
               end
            end
         endcase
         rsp_new.cell_written = item_write_in;
         if (item_write_in) begin
            rsp_new.write_row    = item_row_in;
            rsp_new.write_column = item_col_in;
            rsp_new.write_value  = item_val_in;
         end
         rsp_new.scrolled = item_scroll_in;
      end
   end

   // Physical row of the cell being written: the ring offset has already been
   // reduced below the row count, so one compare and subtract suffices.
   always_comb begin
      phys_sum = {1'b0, top_ff} + {1'b0, item_row_ff};
      if (phys_sum >= rows_eff) begin
         phys_row = ROW_W'(phys_sum - rows_eff);
      end else begin
         phys_row = phys_sum[ROW_W-1:0];
      end
      top_inc = {1'b0, top_ff} + NROW_W'(1);
   end

   assign req_stall  = (state_ff != ttcs_pkg::ST_IDLE) || hold_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_drain  = out_valid_ff && !rsp_stall;
   assign csr_write  = psel && penable && pwrite;
   assign pready     = 1'b1;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;

   always_comb begin
      case (paddr[2])
         ttcs_pkg::CSR_IDX_COLUMNS: prdata = 32'(columns_ff);
         ttcs_pkg::CSR_IDX_ROWS:    prdata = 32'(rows_ff);
         default:                   prdata = '0;
      endcase
   end

   // Next state and store port.
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      top_in        = top_ff;
      blank_row_in  = blank_row_ff;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      ram_we        = 1'b0;
      ram_addr      = sweep_ff;
      ram_wdata     = ttcs_pkg::CODE_SPACE;

      case (state_ff)
         ttcs_pkg::ST_INIT, ttcs_pkg::ST_CLEAR: begin
            ram_we   = 1'b1;
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(ttcs_pkg::DEPTH - 1)) begin
               state_in = ttcs_pkg::ST_IDLE;
            end
         end
         ttcs_pkg::ST_IDLE: begin
            if (req_accept) begin
               cursor_row_in = rsp_new.cursor_row_out;
               cursor_col_in = rsp_new.cursor_column_out;
               if (req_data.mode) begin
                  top_in   = '0;
                  sweep_in = '0;
                  state_in = ttcs_pkg::ST_CLEAR;
               end else begin
                  state_in = ttcs_pkg::ST_REDUCE;
               end
            end
         end
         ttcs_pkg::ST_REDUCE: begin
            // Offset left over from a larger row count: subtract until in range.
            if ({1'b0, top_ff} >= rows_eff) begin
               top_in = ROW_W'({1'b0, top_ff} - rows_eff);
            end else begin
               state_in = ttcs_pkg::ST_WRITE;
            end
         end
         ttcs_pkg::ST_WRITE: begin
            ram_we    = item_write_ff;
            ram_addr  = {phys_row, item_col_ff};
            ram_wdata = item_val_ff;
            if (item_scroll_ff) begin
               blank_row_in = top_ff;
               top_in       = (top_inc == rows_eff) ? '0 : top_inc[ROW_W-1:0];
               sweep_in     = '0;
               state_in     = ttcs_pkg::ST_BLANK;
            end else begin
               state_in = ttcs_pkg::ST_IDLE;
            end
         end
         ttcs_pkg::ST_BLANK: begin
            // The old top row becomes the bottom row and is blanked.
            ram_we   = 1'b1;
            ram_addr = {blank_row_ff, sweep_ff[COL_W-1:0]};
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff[COL_W-1:0] == COL_W'(ttcs_pkg::MAX_COLUMNS - 1)) begin
               state_in = ttcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Configuration and response slots.
   always_comb begin
      columns_in    = columns_ff;
      rows_in       = rows_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;

      if (csr_write) begin
         case (paddr[2])
            ttcs_pkg::CSR_IDX_COLUMNS: columns_in = pwdata[NCOL_W-1:0];
            ttcs_pkg::CSR_IDX_ROWS:    rows_in    = pwdata[NROW_W-1:0];
            default:                   columns_in = columns_ff;
         endcase
      end

      if (rsp_drain) begin
         out_valid_in = 1'b0;
      end
      if (req_accept) begin
         if (!out_valid_ff || rsp_drain) begin
            out_valid_in = 1'b1;
            out_in       = rsp_new;
         end else begin
            hold_valid_in = 1'b1;
            hold_in       = rsp_new;
         end
      end else if (hold_valid_ff && rsp_drain) begin
         out_valid_in  = 1'b1;
         out_in        = hold_ff;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttcs_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= '0;
         top_ff        <= '0;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         columns_ff    <= ttcs_pkg::COLUMNS_RESET;
         rows_ff       <= ttcs_pkg::ROWS_RESET;
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         chk_pend_ff   <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         top_ff        <= top_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         columns_ff    <= columns_in;
         rows_ff       <= rows_in;
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
         chk_valid_ff  <= ram_we;
         chk_pend_ff   <= chk_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      blank_row_ff <= blank_row_in;
      out_ff       <= out_in;
      hold_ff      <= hold_in;
      chk_addr_ff  <= ram_addr;
      chk_data_ff  <= ram_wdata;
      chk_exp_ff   <= chk_data_ff;
      if (req_accept) begin
         item_write_ff  <= item_write_in;
         item_scroll_ff <= item_scroll_in;
         item_row_ff    <= item_row_in;
         item_col_ff    <= item_col_in;
         item_val_ff    <= item_val_in;
      end
   end

   ttcs_ram #(
      .WIDTH (8),
      .DEPTH (ttcs_pkg::DEPTH)
   ) u_cell_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_addr (chk_addr_ff),
      .rd_data (ram_rdata)
   );

   // The second response slot is only filled behind a waiting response.
   assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> out_valid_ff)
      else $error("second response slot holds data while the output is empty");

   // Every accepted request leaves the idle state for its store update.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ttcs_pkg::ST_IDLE)
      else $error("accepted request did not start a store update");

   // The ring offset is in range whenever a cell address is formed from it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ttcs_pkg::ST_WRITE) |-> ({1'b0, top_ff} < rows_eff))
      else $error("ring offset out of range at cell write");

   // A cell read back through the address and read registers after its write holds the written code.
   assert property (@(posedge clock) disable iff (reset)
      chk_pend_ff |-> (ram_rdata == chk_exp_ff))
      else $error("cell store read-back does not match the written code");

endmodule
